// File: design/modpow_pkg.sv
package modpow_pkg;

    localparam int unsigned RES_W = 30;
    localparam int unsigned EXP_W = 63;

    localparam logic [RES_W-1:0] PRIME_MOD  = 30'd1000000007;
    localparam logic [30:0]      BARRETT_MU = 31'd1152921496;
    localparam logic [31:0]      PRIME_X2   = 32'd2000000014;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR_GO,
        ST_SQR_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic sel_base;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic bit_set;
        logic last;
    } dp_status_t;

endpackage

// File: design/modpow_ctrl.sv
module modpow_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  modpow_pkg::dp_status_t status,
    output modpow_pkg::dp_cmd_t    cmd
);

    modpow_pkg::state_t state_reg;
    modpow_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= modpow_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.load     = 1'b0;
        cmd.start    = 1'b0;
        cmd.sel_base = 1'b0;
        cmd.advance  = 1'b0;
        case (state_reg)
            modpow_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = modpow_pkg::ST_SQR_GO;
                end
            end
            modpow_pkg::ST_SQR_GO:
            begin
                cmd.start  = 1'b1;
                state_next = modpow_pkg::ST_SQR_WAIT;
            end
            modpow_pkg::ST_SQR_WAIT:
            begin
                if (status.done)
                begin
                    if (status.bit_set)
                    begin
                        state_next = modpow_pkg::ST_MUL_GO;
                    end
                    else if (status.last)
                    begin
                        state_next = modpow_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = modpow_pkg::ST_SQR_GO;
                    end
                end
            end
            modpow_pkg::ST_MUL_GO:
            begin
                cmd.start    = 1'b1;
                cmd.sel_base = 1'b1;
                state_next   = modpow_pkg::ST_MUL_WAIT;
            end
            modpow_pkg::ST_MUL_WAIT:
            begin
                if (status.done)
                begin
                    if (status.last)
                    begin
                        state_next = modpow_pkg::ST_OUT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = modpow_pkg::ST_SQR_GO;
                    end
                end
            end
            modpow_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = modpow_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = modpow_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/modpow_dp.sv
module modpow_dp
#(
    parameter int EXP_BITS = 63
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  modpow_pkg::dp_cmd_t              cmd,
    input  logic [modpow_pkg::RES_W-1:0]     base,
    input  logic [modpow_pkg::EXP_W-1:0]     exponent,
    output modpow_pkg::dp_status_t           status,
    output logic [modpow_pkg::RES_W-1:0]     power
);

    localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    logic [modpow_pkg::RES_W-1:0] base_reg;
    logic [modpow_pkg::RES_W-1:0] acc_reg;
    logic [EXP_BITS-1:0]          exp_reg;
    logic [CNT_W-1:0]             cnt_reg;

    logic [59:0] prod_reg;
    logic [30:0] q_reg;
    logic [31:0] xlo2_reg;
    logic [31:0] xlo3_reg;
    logic [31:0] qp_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;

    logic [modpow_pkg::RES_W-1:0] base_red;
    logic [modpow_pkg::RES_W-1:0] opb;
    logic [61:0]                  mu_prod;
    logic [31:0]                  rem;
    logic [modpow_pkg::RES_W-1:0] acc_next;

    // base may sit one modulus too high
    assign base_red = (base >= modpow_pkg::PRIME_MOD) ? base - modpow_pkg::PRIME_MOD : base;
    assign opb      = cmd.sel_base ? base_reg : acc_reg;

    // barrett quotient estimate, short by at most two
    assign mu_prod = 62'(prod_reg[59:29]) * 62'(modpow_pkg::BARRETT_MU);
    assign rem     = xlo3_reg - qp_reg;

    always_comb
    begin
        if (rem >= modpow_pkg::PRIME_X2)
        begin
            acc_next = 30'(rem - modpow_pkg::PRIME_X2);
        end
        else if (rem >= 32'(modpow_pkg::PRIME_MOD))
        begin
            acc_next = 30'(rem - 32'(modpow_pkg::PRIME_MOD));
        end
        else
        begin
            acc_next = 30'(rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 60'(acc_reg) * 60'(opb);
        q_reg    <= mu_prod[61:31];
        xlo2_reg <= prod_reg[31:0];
        qp_reg   <= 32'(q_reg) * 32'(modpow_pkg::PRIME_MOD);
        xlo3_reg <= xlo2_reg;
        if (cmd.load)
        begin
            base_reg <= base_red;
            acc_reg  <= 30'd1;
            exp_reg  <= exponent[EXP_BITS-1:0];
            cnt_reg  <= CNT_W'(EXP_BITS - 1);
        end
        else
        begin
            if (v3_reg)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.advance)
            begin
                exp_reg <= exp_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    assign status.done    = v3_reg;
    assign status.bit_set = exp_reg[EXP_BITS-1];
    assign status.last    = (cnt_reg == '0);
    assign power          = acc_reg;

endmodule

// File: design/modular_power_prime_modulus.sv
// channel  dir  tdata fields (low bit up)                   tuser  tlast
// s_       in   base[29:0], exponent[92:30], pad to 96       -      -
// m_       out  power[29:0], pad to 32                      -      -
//
// one word at a time: accept, then one square per scanned exponent bit and
// one multiply per set bit, each through the multiply/barrett pipe
// each square or multiply waits for the previous one to leave that pipe
// rst_n clears the controller and pipe valids; no clearing pass
// s_tready is low from accept until m_tready takes the result; m_tdata holds
module modular_power_prime_modulus
#(
    parameter int EXP_BITS = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // base[29:0], exponent[92:30], zero[95:93]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // power[29:0], zero[31:30]
);

    modpow_pkg::dp_cmd_t    cmd;
    modpow_pkg::dp_status_t status;
    logic [modpow_pkg::RES_W-1:0] power;

    modpow_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    modpow_dp
    #(
        .EXP_BITS (EXP_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .base     (s_tdata[29:0]),
        .exponent (s_tdata[92:30]),
        .status   (status),
        .power    (power)
    );

    assign m_tdata = {2'b00, power};

    // result always fully reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[29:0] < modpow_pkg::PRIME_MOD))
    else $error("power not reduced");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("input open while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !m_tvalid && !s_tready)
    else $error("accepted word not in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> s_tready)
    else $error("not idle after result taken");

endmodule
